// ----- hw/rtl/smr_pkg.sv -----
// Shared types and constants for the stack with running minimum.
`default_nettype none

package smr_pkg;

   localparam int DEPTH     = 1024;
   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]         count_type;
   typedef logic [ADDR_BITS-1:0]        addr_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic start;   // input word accepted this cycle
      logic finish;  // commit the step and load the result word
   } smr_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free;  // result register is empty or drains this cycle
   } smr_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/smr_if.sv -----
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface smr_req_if import smr_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     operation;
   word_type value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface smr_rsp_if import smr_pkg::*; ();
   logic       valid;
   logic       ready;
   word_type   popped_value;
   word_type   current_min;
   logic       min_valid;
   logic [1:0] status;

   modport source (output valid, output popped_value, output current_min,
                   output min_valid, output status, input ready);
   modport sink   (input valid, input popped_value, input current_min,
                   input min_valid, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/smr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/smr_ctrl.sv -----
// Controller state machine: accepts a request word, then commits and emits its result.
`default_nettype none

module smr_ctrl import smr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire smr_sts_type sts,
   output smr_cmd_type      cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Take a word in idle outside reset; finish once the result register has room
   always_comb begin
      req_ready  = (state_ff == S_IDLE) && !reset;
      cmd.start  = req_ready && req_valid;
      cmd.finish = (state_ff == S_EXEC) && sts.slot_free;
      state_in   = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/smr_datapath.sv -----
// Datapath: value and min stores, counters, tracked minimum and result register.
`default_nettype none

module smr_datapath import smr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire smr_cmd_type cmd,
   output smr_sts_type      sts,
   input  wire logic        req_operation,
   input  wire word_type    req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output word_type         rsp_popped_value,
   output word_type         rsp_current_min,
   output logic             rsp_min_valid,
   output logic [1:0]       rsp_status
);

   count_type  count_ff, count_in;
   count_type  min_count_ff, min_count_in;
   word_type   min_top_ff, min_top_in;
   op_type     op_ff;
   status_type status_ff, status_in;

   logic       rsp_valid_ff, rsp_valid_in;
   word_type   popped_ff, popped_in;
   word_type   cur_min_ff, cur_min_in;
   logic       min_valid_ff, min_valid_in;
   status_type rsp_status_ff;

   op_type     req_op;
   logic       push_ok, pop_ok, push_min;
   logic       val_wr, min_wr, rd_en, min_rd_en;
   addr_type   val_rd_addr, min_rd_addr;
   word_type   val_rd_data, min_rd_data;
   logic       pop_commit, pop_min;
   count_type  new_count, new_min_count;
   word_type   new_min_top;

   // Decode the request at acceptance
   always_comb begin
      req_op      = op_type'(req_operation);
      push_ok     = (count_ff != CNT_BITS'(DEPTH));
      pop_ok      = (count_ff != '0);
      push_min    = ((min_count_ff == '0) || (req_value <= min_top_ff))
                    && (min_count_ff != CNT_BITS'(DEPTH));
      val_wr      = cmd.start && (req_op == OP_PUSH) && push_ok;
      min_wr      = val_wr && push_min;
      rd_en       = cmd.start && (req_op == OP_POP) && pop_ok;
      // read below the min top only when such an entry exists
      min_rd_en   = rd_en && (min_count_ff > CNT_BITS'(1));
      // top of stack and the entry below the min top
      val_rd_addr = count_ff[ADDR_BITS-1:0] - ADDR_BITS'(1);
      min_rd_addr = min_count_ff[ADDR_BITS-1:0] - ADDR_BITS'(2);
   end

   smr_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   smr_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_min_ram (
      .clock   (clock),
      .wr_en   (min_wr),
      .wr_addr (min_count_ff[ADDR_BITS-1:0]),
      .wr_data (req_value),
      .rd_en   (min_rd_en),
      .rd_addr (min_rd_addr),
      .rd_data (min_rd_data)
   );

   // Pop commit: drop the top word, and the min top when it leaves
   always_comb begin
      pop_commit    = cmd.finish && (op_ff == OP_POP) && (status_ff == ST_OK);
      new_count     = count_ff;
      new_min_count = min_count_ff;
      new_min_top   = min_top_ff;
      pop_min       = 1'b0;
      if (op_ff == OP_POP && status_ff == ST_OK) begin
         new_count = count_ff - CNT_BITS'(1);
         pop_min   = (min_count_ff != '0)
                     && ((new_count == '0) || (val_rd_data == min_top_ff));
         if (pop_min) begin
            new_min_count = min_count_ff - CNT_BITS'(1);
            new_min_top   = min_rd_data;
         end
      end
   end

   // Next state of counters and tracked minimum
   always_comb begin
      count_in     = count_ff;
      min_count_in = min_count_ff;
      min_top_in   = min_top_ff;
      status_in    = status_ff;
      if (cmd.start) begin
         if (req_op == OP_PUSH) begin
            status_in = push_ok ? ST_OK : ST_FULL;
         end else begin
            status_in = pop_ok ? ST_OK : ST_EMPTY;
         end
      end
      if (val_wr) begin
         count_in = count_ff + CNT_BITS'(1);
      end
      if (min_wr) begin
         min_count_in = min_count_ff + CNT_BITS'(1);
         min_top_in   = req_value;
      end
      if (pop_commit) begin
         count_in     = new_count;
         min_count_in = new_min_count;
         min_top_in   = new_min_top;
      end
   end

   // Result word and its valid flag
   always_comb begin
      sts.slot_free = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      popped_in     = popped_ff;
      cur_min_in    = cur_min_ff;
      min_valid_in  = min_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         popped_in    = (op_ff == OP_POP && status_ff == ST_OK) ? val_rd_data : '0;
         min_valid_in = (new_count != '0) && (new_min_count != '0);
         cur_min_in   = min_valid_in ? new_min_top : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_count_ff <= min_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      min_top_ff   <= min_top_in;
      status_ff    <= status_in;
      popped_ff    <= popped_in;
      cur_min_ff   <= cur_min_in;
      min_valid_ff <= min_valid_in;
      if (cmd.start) begin
         op_ff <= req_op;
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_current_min  = cur_min_ff;
   assign rsp_min_valid    = min_valid_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/stack_with_running_min.sv -----
// A result word is loaded into the output register for rsp_chan as the controller leaves
// S_EXEC, where it waits while that register is full; a new request waits for S_IDLE. A pop
// launches reads of the value and min RAMs at acceptance; the registered data is used at finish.
// The next request is taken while an earlier result still waits in the output register.
// Reset (synchronous, active high) empties the stack; the stores need no clearing pass.
`default_nettype none

module stack_with_running_min import smr_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   smr_req_if.sink  req_chan,
   smr_rsp_if.source rsp_chan
);

   smr_cmd_type cmd;
   smr_sts_type sts;
   logic        req_ready;

   smr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   smr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_chan.operation),
      .req_value        (req_chan.value),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_popped_value (rsp_chan.popped_value),
      .rsp_current_min  (rsp_chan.current_min),
      .rsp_min_valid    (rsp_chan.min_valid),
      .rsp_status       (rsp_chan.status)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
